// ===== rtl/wrc_pkg.sv =====
// Shared types, constants and SHA-256 helpers for the watermark record checker.
// Used by the datapath, the controller and the top level.
package wrc_pkg;

  localparam int RecLen  = 33;
  localparam int SumSpan = 29;
  localparam int CntW    = 6;

  localparam logic [7:0] Magic0 = 8'h4E;
  localparam logic [7:0] Magic1 = 8'h58;
  localparam logic [7:0] Magic2 = 8'h57;
  localparam logic [7:0] Magic3 = 8'h4D;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusShort    = 2'd1;
  localparam logic [1:0] StatusBadMagic = 2'd2;
  localparam logic [1:0] StatusBadSum   = 2'd3;

  typedef enum logic [2:0] {
    ST_COLLECT, ST_INIT, ST_ROUND, ST_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic store_byte;
    logic clear_count;
    logic hash_init;
    logic hash_round;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic       count_full;
    logic       round_last;
    logic       magic_ok;
  } stat_t;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        user_hash;
    logic [63:0]        device_hash;
    logic signed [63:0] stamp;
  } out_word_t;

  function automatic logic [31:0] sha_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  localparam logic [31:0] HInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/wrc_if.sv =====
// Valid/ready channel carrying one word of payload type T.
// Depends on nothing.
interface wrc_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/wrc_datapath.sv =====
// Record store, byte counter, SHA-256 round unit and result register.
// Depends on wrc_pkg.
module wrc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  wrc_pkg::cmd_t     cmd,
  output wrc_pkg::stat_t    stat,
  input  logic [7:0]        record_byte,
  output logic [1:0]        status,
  output logic [63:0]       user_hash,
  output logic [63:0]       device_hash,
  output logic [63:0]       stamp
);

  // Bytes 0..28 sit in the store; bytes 29..32 shift into the check word.
  logic [7:0]  store [wrc_pkg::SumSpan];
  logic [wrc_pkg::CntW-1:0] byte_count;
  logic [5:0]  round_index;
  logic [31:0] sched [16];
  logic [31:0] v [8];
  logic [31:0] w, blk_w, w15, w2, s0, s1, ch, mj, t1, t2;
  logic [31:0] want;
  logic [7:0]  blk [64];
  logic        short_q;

  assign stat.count_full = (byte_count == 6'(wrc_pkg::RecLen));
  assign stat.round_last = (round_index == 6'd63);
  assign stat.magic_ok = store[0] == wrc_pkg::Magic0 && store[1] == wrc_pkg::Magic1 &&
                         store[2] == wrc_pkg::Magic2 && store[3] == wrc_pkg::Magic3;

  // Padded message block: bytes 0..28, then the end marker and the bit length.
  always_comb begin
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < wrc_pkg::SumSpan; i++) blk[i] = store[i];
    blk[wrc_pkg::SumSpan] = 8'h80;
    blk[62] = 8'(((wrc_pkg::SumSpan * 8) >> 8));
    blk[63] = 8'((wrc_pkg::SumSpan * 8));
  end

  always_comb begin
    blk_w = {blk[{round_index[3:0], 2'd0}], blk[{round_index[3:0], 2'd1}],
             blk[{round_index[3:0], 2'd2}], blk[{round_index[3:0], 2'd3}]};
    w15 = sched[4'(round_index - 6'd15)];
    w2  = sched[4'(round_index - 6'd2)];
    s0 = wrc_pkg::rotr(w15, 7) ^ wrc_pkg::rotr(w15, 18) ^ (w15 >> 3);
    s1 = wrc_pkg::rotr(w2, 17) ^ wrc_pkg::rotr(w2, 19) ^ (w2 >> 10);
    if (round_index < 6'd16) w = blk_w;
    else w = sched[round_index[3:0]] + s0 + sched[4'(round_index - 6'd7)] + s1;
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + (wrc_pkg::rotr(v[4], 6) ^ wrc_pkg::rotr(v[4], 11) ^ wrc_pkg::rotr(v[4], 25))
         + ch + wrc_pkg::sha_k(round_index) + w;
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = (wrc_pkg::rotr(v[0], 2) ^ wrc_pkg::rotr(v[0], 13) ^ wrc_pkg::rotr(v[0], 22)) + mj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      round_index <= '0;
    end else begin
      if (cmd.clear_count) byte_count <= '0;
      else if (cmd.store_byte && !stat.count_full) byte_count <= byte_count + 6'd1;
      if (cmd.hash_init) round_index <= '0;
      else if (cmd.hash_round) round_index <= round_index + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte && !stat.count_full) begin
      if (byte_count < 6'(wrc_pkg::SumSpan)) store[byte_count[4:0]] <= record_byte;
      else want <= {want[23:0], record_byte};
    end
    if (cmd.hash_init) begin
      for (int i = 0; i < 8; i++) v[i] <= wrc_pkg::HInit[i];
      short_q <= !stat.count_full;
    end else if (cmd.hash_round) begin
      sched[round_index[3:0]] <= w;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
    if (cmd.load_result) begin
      user_hash <= '0; device_hash <= '0; stamp <= '0;
      if (short_q) status <= wrc_pkg::StatusShort;
      else if (!stat.magic_ok) status <= wrc_pkg::StatusBadMagic;
      else if (wrc_pkg::HInit[0] + v[0] != want) status <= wrc_pkg::StatusBadSum;
      else begin
        status <= wrc_pkg::StatusOk;
        for (int i = 0; i < 8; i++) begin
          user_hash[63-8*i -: 8] <= store[5+i];
          device_hash[63-8*i -: 8] <= store[13+i];
          stamp[63-8*i -: 8] <= store[21+i];
        end
      end
    end
  end

endmodule

// ===== rtl/wrc_ctrl.sv =====
// Sequencer: takes bytes, runs 64 hash rounds on the final byte, holds result.
// Depends on wrc_pkg.
module wrc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  wrc_pkg::stat_t  stat,
  output wrc_pkg::cmd_t   cmd
);

  wrc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= wrc_pkg::ST_COLLECT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      wrc_pkg::ST_COLLECT: if (in_valid && in_last) state_next = wrc_pkg::ST_INIT;
      wrc_pkg::ST_INIT:    state_next = wrc_pkg::ST_ROUND;
      wrc_pkg::ST_ROUND:   if (stat.round_last) state_next = wrc_pkg::ST_DONE;
      wrc_pkg::ST_DONE:    state_next = wrc_pkg::ST_OUT;
      wrc_pkg::ST_OUT:     if (out_ready) state_next = wrc_pkg::ST_COLLECT;
      default:             state_next = wrc_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      wrc_pkg::ST_COLLECT: begin
        in_ready = 1'b1;
        cmd.store_byte = in_valid;
      end
      wrc_pkg::ST_INIT:  cmd.hash_init = 1'b1;
      wrc_pkg::ST_ROUND: cmd.hash_round = 1'b1;
      wrc_pkg::ST_DONE: begin
        cmd.load_result = 1'b1;
        cmd.clear_count = 1'b1;
      end
      wrc_pkg::ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/watermark_record_checker_unit.sv =====
// Watermark record checker: one byte word per cycle is taken while collecting.
// The final byte starts an init step, 64 hash rounds and a result load, after which
// the result is held valid until it is taken.
// Input is ready again the cycle after the result is taken; no bytes of a new record
// are taken while a record is hashed or its result is held.
// Synchronous reset clears the byte count, round counter and sequencer state.
module watermark_record_checker_unit (
  input logic clk,
  input logic rst,
  wrc_if.sink   in_ch,
  wrc_if.source out_ch
);

  wrc_pkg::cmd_t  cmd;
  wrc_pkg::stat_t stat;

  wrc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_last(in_ch.data.last_byte), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  wrc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .record_byte(in_ch.data.record_byte),
    .status(out_ch.data.status), .user_hash(out_ch.data.user_hash),
    .device_hash(out_ch.data.device_hash), .stamp(out_ch.data.stamp)
  );

endmodule

// ===== tb/tb_watermark_record_checker_unit.sv =====
// Self-checking testbench for watermark_record_checker_unit: byte records in, one verdict out.
// Depends on rtl/wrc_pkg.sv, rtl/wrc_if.sv and the top level of the block.
module tb_watermark_record_checker_unit;

  typedef wrc_pkg::in_word_t  rec_word_t;
  typedef wrc_pkg::out_word_t verdict_t;

  typedef struct {
    rec_word_t w;
    int        mode;
  } pending_t;

  localparam int IdleNone = 0, IdleSend = 1, IdleRecv = 2, IdleBoth = 3;
  localparam int StallLimit = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wrc_if #(.T(rec_word_t)) in_ch ();
  wrc_if #(.T(verdict_t))  out_ch ();

  watermark_record_checker_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pending_t  byte_queue[$];
  verdict_t  verdict_queue[$];
  logic [7:0] rec_bytes[33];
  int        rec_fill = 0;
  int        errors = 0;
  int        stall_cnt = 0;
  int        cur_mode = IdleNone;
  logic      in_fire = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // First digest word of SHA-256 over a 29-byte message (one padded block).
  function automatic logic [31:0] digest_head(logic [7:0] msg[33]);
    logic [31:0] kc[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    logic [31:0] iv[8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    logic [7:0]  blk[64];
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 29; i++) blk[i] = msg[i];
    blk[29] = 8'h80;
    blk[62] = 8'h00;
    blk[63] = 8'hE8;  // 29 bytes is 232 bits
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      end else begin
        s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
    end
    {a, b, c, d, e, f, g, h} = {iv[0], iv[1], iv[2], iv[3], iv[4], iv[5], iv[6], iv[7]};
    for (int t = 0; t < 64; t++) begin
      s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + kc[t] + w[t];
      s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return iv[0] + a;
  endfunction

  // Track the record as words are accepted and predict the verdict on the final byte.
  task automatic take_byte(rec_word_t w);
    verdict_t v;
    if (rec_fill < wrc_pkg::RecLen) begin
      rec_bytes[rec_fill] = w.record_byte;
      rec_fill++;
    end
    if (w.last_byte) begin
      v = '0;
      if (rec_fill < wrc_pkg::RecLen) begin
        v.status = wrc_pkg::StatusShort;
      end else if (rec_bytes[0] != wrc_pkg::Magic0 || rec_bytes[1] != wrc_pkg::Magic1 ||
                   rec_bytes[2] != wrc_pkg::Magic2 || rec_bytes[3] != wrc_pkg::Magic3) begin
        v.status = wrc_pkg::StatusBadMagic;
      end else if (digest_head(rec_bytes) !=
                   {rec_bytes[29], rec_bytes[30], rec_bytes[31], rec_bytes[32]}) begin
        v.status = wrc_pkg::StatusBadSum;
      end else begin
        v.status = wrc_pkg::StatusOk;
        for (int i = 0; i < 8; i++) begin
          v.user_hash   = {v.user_hash[55:0], rec_bytes[5+i]};
          v.device_hash = {v.device_hash[55:0], rec_bytes[13+i]};
          v.stamp       = {v.stamp[55:0], rec_bytes[21+i]};
        end
      end
      verdict_queue.push_back(v);
      rec_fill = 0;
    end
  endtask

  // Monitor: record accepted words on both channels.
  always @(posedge clk) begin
    verdict_t got, want;
    in_fire = !rst && in_ch.valid && in_ch.ready;
    if (in_fire) take_byte(in_ch.data);
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (verdict_queue.size() == 0) begin
        $display("%0t: unexpected verdict %h", $time, got);
        errors++;
      end else begin
        want = verdict_queue.pop_front();
        if (got.status !== want.status)
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        if (got.user_hash !== want.user_hash)
          $display("%0t: user_hash exp %h got %h", $time, want.user_hash, got.user_hash);
        if (got.device_hash !== want.device_hash)
          $display("%0t: device_hash exp %h got %h", $time, want.device_hash, got.device_hash);
        if (got.stamp !== want.stamp)
          $display("%0t: stamp exp %h got %h", $time, want.stamp, got.stamp);
        if (got !== want) errors++;
      end
    end
  end

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    pending_t p;
    if (!rst) begin
      if (!in_ch.valid || in_fire) begin
        if (byte_queue.size() > 0) begin
          cur_mode = byte_queue[0].mode;
          if ((cur_mode == IdleSend || cur_mode == IdleBoth) &&
              $urandom_range(99) < (cur_mode == IdleSend ? 69 : 13)) begin
            in_ch.valid <= 1'b0;
          end else begin
            p = byte_queue.pop_front();
            in_ch.data  <= p.w;
            in_ch.valid <= 1'b1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (cur_mode == IdleRecv)
        out_ch.ready <= ($urandom_range(99) >= 69);
      else if (cur_mode == IdleBoth)
        out_ch.ready <= ($urandom_range(99) >= 13);
      else
        out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_word(logic [7:0] b, logic l, int mode);
    pending_t p;
    p.w.record_byte = b;
    p.w.last_byte = l;
    p.mode = mode;
    byte_queue.push_back(p);
  endtask

  // kind: 0 good, 1 bad checksum, 2 bad magic, 3 short, 4 long (good, extra bytes)
  task automatic push_record(int kind, int mode);
    logic [7:0] r[33];
    logic [31:0] sum;
    int extra;
    for (int i = 0; i < 33; i++) r[i] = 8'($urandom_range(255));
    r[0] = wrc_pkg::Magic0; r[1] = wrc_pkg::Magic1;
    r[2] = wrc_pkg::Magic2; r[3] = wrc_pkg::Magic3;
    if (kind == 2) r[$urandom_range(3)] ^= 8'd1 << $urandom_range(7);
    sum = digest_head(r);
    {r[29], r[30], r[31], r[32]} = sum;
    if (kind == 1) r[29 + $urandom_range(3)] ^= 8'd1 << $urandom_range(7);
    if (kind == 3) begin
      extra = $urandom_range(32, 1);
      for (int i = 0; i < extra; i++) push_word(r[i], i == extra - 1, mode);
    end else if (kind == 4) begin
      extra = $urandom_range(5, 1);
      for (int i = 0; i < 33; i++) push_word(r[i], 1'b0, mode);
      for (int i = 0; i < extra; i++) push_word(8'($urandom_range(255)), i == extra - 1, mode);
    end else begin
      for (int i = 0; i < 33; i++) push_word(r[i], i == 32, mode);
    end
  endtask

  initial begin
    logic [7:0] r[33];
    int pick, mode;
    // Directed: one-byte record, a good record with all-ones and all-zero fields, then a two-byte record.
    push_word(8'hFF, 1'b1, IdleNone);
    for (int i = 0; i < 33; i++) r[i] = (i >= 5 && i < 13) ? 8'hFF : 8'h00;
    r[0] = wrc_pkg::Magic0; r[1] = wrc_pkg::Magic1;
    r[2] = wrc_pkg::Magic2; r[3] = wrc_pkg::Magic3;
    r[21] = 8'h80;  // most negative stamp
    {r[29], r[30], r[31], r[32]} = digest_head(r);
    for (int i = 0; i < 33; i++) push_word(r[i], i == 32, IdleNone);
    push_word(8'h00, 1'b0, IdleNone);
    push_word(8'h00, 1'b1, IdleNone);
    // Random records, grouped into idling phases.
    while (byte_queue.size() < 1300) begin
      mode = (byte_queue.size() / 330) % 4;
      pick = $urandom_range(99);
      if (pick < 55) push_record(0, mode);
      else if (pick < 70) push_record(1, mode);
      else if (pick < 80) push_record(2, mode);
      else if (pick < 92) push_record(3, mode);
      else push_record(4, mode);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (byte_queue.size() == 0 && !in_ch.valid);
    wait (verdict_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && verdict_queue.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
